/* src/blr_pkg.sv */
// shared constants and types of the line rasterizer
package blr_pkg;

  // default coordinate width and fixed color width
  localparam int BLR_COORD_BITS = 12;
  localparam int BLR_COLOR_BITS = 24;

  // item function codes
  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // step directions and major axis of a line
  typedef struct packed {
    logic x_down;
    logic y_down;
    logic steep;
  } line_dir_t;

endpackage

/* src/bresenham_line_rasterizer_top.sv */
// bresenham line rasterizer: input register, line datapath, result register
// an accepted item is held in the input register, and its pixel is then registered in the result register
// throughput: one item per cycle, one pixel per cycle along a line, while out_ready does not stall the output
// the line setup and one add/compare step lie between the input register and the line state
// reset: synchronous, leaves both registers empty and the line idle
module bresenham_line_rasterizer_top
  import blr_pkg::*;
#(
  parameter int COORD_BITS = BLR_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [BLR_COLOR_BITS-1:0]    color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [BLR_COLOR_BITS-1:0]    pixel_color,
  output logic                         last_pixel
);

  // input register
  logic                         ival;
  logic                         i_func;
  logic signed [COORD_BITS-1:0] i_sx;
  logic signed [COORD_BITS-1:0] i_sy;
  logic signed [COORD_BITS-1:0] i_ex;
  logic signed [COORD_BITS-1:0] i_ey;
  logic [BLR_COLOR_BITS-1:0]    i_color;

  logic                         move;
  logic                         load;
  logic        [COORD_BITS-1:0] s_adx;
  logic        [COORD_BITS-1:0] s_ady;
  line_dir_t                    s_dir;
  logic        [COORD_BITS+2:0] s_err;
  logic        [COORD_BITS:0]   s_count;
  logic                         emit;
  logic signed [COORD_BITS-1:0] r_x;
  logic signed [COORD_BITS-1:0] r_y;
  logic [BLR_COLOR_BITS-1:0]    r_color;
  logic                         r_last;

  // the held item moves on when the result register can take it
  assign move     = ival && (!out_valid || out_ready);
  assign in_ready = !ival || move;
  assign load     = ival && (i_func == FUNC_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      ival <= 1'b0;
    end else if (in_valid && in_ready) begin
      ival <= 1'b1;
    end else if (move) begin
      ival <= 1'b0;
    end
    if (in_valid && in_ready) begin
      i_func  <= func;
      i_sx    <= start_x;
      i_sy    <= start_y;
      i_ex    <= end_x;
      i_ey    <= end_y;
      i_color <= color;
    end
  end

  // line setup from the held endpoints
  blr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x    (i_sx),
    .start_y    (i_sy),
    .end_x      (i_ex),
    .end_y      (i_ey),
    .abs_dx     (s_adx),
    .abs_dy     (s_ady),
    .dir        (s_dir),
    .init_err   (s_err),
    .pixel_count(s_count)
  );

  // line state and pixel stepping
  blr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk      (clk),
    .rst      (rst),
    .go       (move),
    .load     (load),
    .start_x  (i_sx),
    .start_y  (i_sy),
    .color    (i_color),
    .new_adx  (s_adx),
    .new_ady  (s_ady),
    .new_dir  (s_dir),
    .new_err  (s_err),
    .new_count(s_count),
    .emit     (emit),
    .px       (r_x),
    .py       (r_y),
    .pcolor   (r_color),
    .plast    (r_last)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (move && emit) begin
      pixel_x     <= r_x;
      pixel_y     <= r_y;
      pixel_color <= r_color;
      last_pixel  <= r_last;
    end
  end

endmodule

/* src/blr_setup.sv */
// line setup: deltas, directions, major axis, initial error and pixel count
module blr_setup
  import blr_pkg::*;
#(
  parameter int COORD_BITS = BLR_COORD_BITS
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic        [COORD_BITS-1:0] abs_dx,
  output logic        [COORD_BITS-1:0] abs_dy,
  output line_dir_t                    dir,
  output logic        [COORD_BITS+2:0] init_err,
  output logic        [COORD_BITS:0]   pixel_count
);

  localparam int N = COORD_BITS;

  logic [N:0]   dx;
  logic [N:0]   dy;
  logic [N:0]   dx_mag;
  logic [N:0]   dy_mag;
  logic [N-1:0] major;
  logic [N-1:0] minor;

  // signed deltas, one bit wider than the coordinates
  assign dx = {end_x[N-1], end_x} - {start_x[N-1], start_x};
  assign dy = {end_y[N-1], end_y} - {start_y[N-1], start_y};

  // magnitudes always fit in N bits
  assign dx_mag = dx[N] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[N] ? (~dy + 1'b1) : dy;
  assign abs_dx = dx_mag[N-1:0];
  assign abs_dy = dy_mag[N-1:0];

  // direction flags, diagonal lines count as steep
  assign dir.x_down = dx[N];
  assign dir.y_down = dy[N];
  assign dir.steep  = (abs_dy >= abs_dx);

  assign major = dir.steep ? abs_dy : abs_dx;
  assign minor = dir.steep ? abs_dx : abs_dy;

  // error start is 2*minor - major, count includes both endpoints
  assign init_err    = {2'b00, minor, 1'b0} - {3'b000, major};
  assign pixel_count = {1'b0, major} + {{N{1'b0}}, 1'b1};

endmodule

/* src/blr_stepper.sv */
// line state registers and the per-pixel emit and advance datapath
module blr_stepper
  import blr_pkg::*;
#(
  parameter int COORD_BITS = BLR_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic [BLR_COLOR_BITS-1:0]    color,
  input  logic        [COORD_BITS-1:0] new_adx,
  input  logic        [COORD_BITS-1:0] new_ady,
  input  line_dir_t                    new_dir,
  input  logic        [COORD_BITS+2:0] new_err,
  input  logic        [COORD_BITS:0]   new_count,
  output logic                         emit,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic [BLR_COLOR_BITS-1:0]    pcolor,
  output logic                         plast
);

  localparam int N = COORD_BITS;
  localparam logic [N-1:0] ONE_C = {{(N-1){1'b0}}, 1'b1};
  localparam logic [N:0]   ONE_L = {{N{1'b0}}, 1'b1};

  // line state
  logic                      line_active;
  logic [N-1:0]              cur_x;
  logic [N-1:0]              cur_y;
  logic [N+2:0]              decision_error;
  logic [N:0]                pixels_left;
  logic [N-1:0]              abs_dx;
  logic [N-1:0]              abs_dy;
  line_dir_t                 dir;
  logic [BLR_COLOR_BITS-1:0] line_color;

  // effective values: a load overrides the stored line
  logic [N-1:0]              eff_x;
  logic [N-1:0]              eff_y;
  logic [N+2:0]              eff_err;
  logic [N:0]                eff_left;
  logic [N-1:0]              eff_adx;
  logic [N-1:0]              eff_ady;
  line_dir_t                 eff_dir;
  logic [BLR_COLOR_BITS-1:0] eff_color;

  logic [N:0]   left_next;
  logic [N+2:0] minor2;
  logic [N+2:0] major2;
  logic         err_neg;
  logic         step_x;
  logic         step_y;
  logic [N-1:0] x_next;
  logic [N-1:0] y_next;
  logic [N+2:0] err_next;

  assign eff_x     = load ? start_x   : cur_x;
  assign eff_y     = load ? start_y   : cur_y;
  assign eff_err   = load ? new_err   : decision_error;
  assign eff_left  = load ? new_count : pixels_left;
  assign eff_adx   = load ? new_adx   : abs_dx;
  assign eff_ady   = load ? new_ady   : abs_dy;
  assign eff_dir   = load ? new_dir   : dir;
  assign eff_color = load ? color     : line_color;

  // pixel out of the current position
  assign emit   = load || line_active;
  assign px     = eff_x;
  assign py     = eff_y;
  assign pcolor = eff_color;
  assign plast  = (eff_left == ONE_L);

  assign left_next = eff_left - ONE_L;

  // one bresenham step along the major axis
  assign minor2  = eff_dir.steep ? {2'b00, eff_adx, 1'b0} : {2'b00, eff_ady, 1'b0};
  assign major2  = eff_dir.steep ? {2'b00, eff_ady, 1'b0} : {2'b00, eff_adx, 1'b0};
  assign err_neg = eff_err[N+2];
  assign step_x  = !eff_dir.steep || !err_neg;
  assign step_y  = eff_dir.steep || !err_neg;

  always_comb begin
    x_next = eff_x;
    y_next = eff_y;
    if (step_x) begin
      x_next = eff_dir.x_down ? (eff_x - ONE_C) : (eff_x + ONE_C);
    end
    if (step_y) begin
      y_next = eff_dir.y_down ? (eff_y - ONE_C) : (eff_y + ONE_C);
    end
    err_next = err_neg ? (eff_err + minor2) : (eff_err + minor2 - major2);
  end

  // state update when an item leaves the input register with a pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      pixels_left <= '0;
    end else if (go && emit) begin
      line_active    <= (left_next != '0);
      pixels_left    <= left_next;
      cur_x          <= x_next;
      cur_y          <= y_next;
      decision_error <= err_next;
      abs_dx         <= eff_adx;
      abs_dy         <= eff_ady;
      dir            <= eff_dir;
      line_color     <= eff_color;
    end
  end

endmodule
